// ===== hdl/ihst_pkg.sv =====
// Shared widths, codes and helper functions for the implicit heat step block.
package ihst_pkg;

    localparam int LAM_W  = 48;
    localparam int TMP_W  = 32;
    localparam int P_W    = 32;
    localparam int D_W    = 40;
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 40;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int NUM_W  = 89;
    localparam int DEN_W  = 50;
    localparam int NCFG_W = 12;
    localparam int IDX_W  = 11;

    localparam logic [1:0] CMD_FILL = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] REG_LAMBDA = 2'd0;
    localparam logic [1:0] REG_NODES  = 2'd1;
    localparam logic [1:0] REG_INIT   = 2'd2;

    localparam logic [LAM_W-1:0]  LAMBDA_RST = 48'd65536;
    localparam logic [NCFG_W-1:0] NODES_RST  = 12'd2048;
    localparam logic [TMP_W-1:0]  INIT_RST   = 32'd19660800;

    localparam logic [DEN_W:0]  ONE_Q16 = 51'd65536;
    localparam logic [D_W-1:0]  D_MAX   = {D_W{1'b1}};

    // Q16.24 to Q16.16 with rounding, saturated
    function automatic logic [TMP_W-1:0] to_q16(input logic [D_W-1:0] x);
        logic [D_W:0] s;
        s = {1'b0, x} + (D_W+1)'(128);
        to_q16 = s[D_W] ? {TMP_W{1'b1}} : s[D_W-1:8];
    endfunction

    function automatic logic [D_W-1:0] sat_d(input logic [NUM_W-1:0] q);
        sat_d = (q[NUM_W-1:D_W] != '0) ? D_MAX : q[D_W-1:0];
    endfunction

endpackage

// ===== hdl/ihst_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module ihst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/ihst_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module ihst_mul
    import ihst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [PROD_W-1:0]  o_prod
);
    localparam int CNT_W = $clog2(MUL_B_W);

    logic               r_busy, r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_acc, r_a;
    logic [MUL_B_W-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(MUL_B_W-1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= PROD_W'(i_a);
            r_b   <= i_b;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== hdl/ihst_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ihst_div
    import ihst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [DEN_W:0]   w_trial, w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(NUM_W-1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits DEN_W bits
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

// ===== hdl/implicit_heat_step_tridiagonal.sv =====
// Top level: implicit heat step on a 1-D rod, Thomas solver over on-chip RAMs.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  cmd in  | i_s_tvalid / o_s_tready    | tuser: command; tdata: boundary, node_index
//  result  | o_m_tvalid / i_m_tready    | tdata: temp_value; tuser: index_error
//  config  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A step runs a forward pass with two serial multiplies and two serial divides
// per row (one divide on the last, insulated row), then back substitution with
// one serial multiply per row.
// Reset clears control and loads register defaults; RAM contents are not cleared.
// A result waiting on i_m_tready holds the sequencer in its final state only.
module implicit_heat_step_tridiagonal
    import ihst_pkg::*;
#(
    parameter int MAX_NODES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [31:0] boundary_temp, [42:32] node_index
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] temp_value
    output logic [0:0]  o_m_tuser,   // [0] index_error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_RDW  = 4'd2;
    localparam logic [3:0] S_F0   = 4'd3;
    localparam logic [3:0] S_FRD  = 4'd4;
    localparam logic [3:0] S_FLP  = 4'd5;
    localparam logic [3:0] S_FDP  = 4'd6;
    localparam logic [3:0] S_FMD  = 4'd7;
    localparam logic [3:0] S_FDD  = 4'd8;
    localparam logic [3:0] S_BST  = 4'd9;
    localparam logic [3:0] S_BRD  = 4'd10;
    localparam logic [3:0] S_BRW  = 4'd11;
    localparam logic [3:0] S_BMW  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0]        r_state;
    logic [LAM_W-1:0]  r_lam;
    logic [NCFG_W-1:0] r_ncfg;
    logic [TMP_W-1:0]  r_init;
    logic [CW-1:0]     r_n;
    logic [AW-1:0]     r_i;
    logic [P_W-1:0]    r_p, r_pn;
    logic [D_W-1:0]    r_d, r_x;
    logic [DEN_W-1:0]  r_den;
    logic [TMP_W-1:0]  r_res;
    logic              r_err;
    logic              r_ovalid;
    logic [TMP_W-1:0]  r_odata;
    logic              r_oerr;

    logic              w_accept, w_last, w_in_range, w_load;
    logic [1:0]        w_cmd;
    logic [TMP_W-1:0]  w_bnd;
    logic [IDX_W-1:0]  w_idx;
    logic [CW-1:0]     w_n;
    logic [DEN_W:0]    w_den;
    logic [D_W-1:0]    w_dn, w_t, w_xn;
    logic [D_W:0]      w_xsum;

    logic              t_we, t_re, c_we, c_re;
    logic [AW-1:0]     t_waddr, t_raddr, c_waddr, c_raddr;
    logic [TMP_W-1:0]  t_wdata, t_rdata;
    logic [P_W-1:0]    p_wdata, p_rdata;
    logic [D_W-1:0]    d_wdata, d_rdata;

    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_quo;
    logic [DEN_W-1:0]   div_den;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_cmd       = i_s_tuser;
    assign w_bnd       = i_s_tdata[31:0];
    assign w_idx       = i_s_tdata[42:32];

    always_comb begin
        if (32'(r_ncfg) < 32'd2) begin
            w_n = CW'(2);
        end else if (32'(r_ncfg) > 32'(MAX_NODES)) begin
            w_n = CW'(MAX_NODES);
        end else begin
            w_n = CW'(r_ncfg);
        end
    end

    assign w_in_range = 32'(w_idx) < 32'(w_n);
    assign w_last     = (r_i == AW'(r_n - CW'(1)));

    // den = 1 + 2L - lp for interior rows, 1 + L - lp for the insulated row
    assign w_den = ONE_Q16 + (w_last ? {3'b0, r_lam} : {2'b0, r_lam, 1'b0})
                 - {3'b0, mul_prod[79:32]};
    assign w_dn  = sat_d(div_quo);
    assign w_t   = mul_prod[71:32];
    assign w_xsum = {1'b0, d_rdata} + {1'b0, w_t};
    assign w_xn   = w_xsum[D_W] ? D_MAX : w_xsum[D_W-1:0];
    assign w_load = (r_state == S_DONE) && (!r_ovalid || i_m_tready);

    always_comb begin
        t_we = 1'b0; t_waddr = r_i; t_wdata = r_init;
        t_re = 1'b0; t_raddr = r_i;
        c_we = 1'b0; c_waddr = r_i; p_wdata = r_pn; d_wdata = w_dn;
        c_re = 1'b0; c_raddr = r_i - AW'(1);
        mul_start = 1'b0; mul_a = r_lam; mul_b = MUL_B_W'(r_p);
        div_start = 1'b0; div_num = NUM_W'({r_lam, 32'b0}); div_den = w_den[DEN_W-1:0];
        case (r_state)
            S_IDLE: begin
                t_re    = w_accept && (w_cmd == CMD_READ) && w_in_range;
                t_raddr = AW'(w_idx);
            end
            S_FILL: begin
                t_we = 1'b1;
            end
            S_F0: begin
                c_we    = 1'b1;
                p_wdata = r_p;
                d_wdata = r_d;
            end
            S_FRD: begin
                t_re      = 1'b1;
                mul_start = 1'b1;
            end
            S_FLP: begin
                if (mul_done) begin
                    if (w_last) begin
                        mul_start = 1'b1;
                        mul_b     = r_d;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            S_FDP: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_b     = r_d;
                end
            end
            S_FMD: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(mul_prod) + NUM_W'({t_rdata, 24'b0});
                    div_den   = r_den;
                end
            end
            S_FDD: begin
                c_we = div_done;
            end
            S_BST: begin
                t_we    = 1'b1;
                t_wdata = to_q16(r_d);
            end
            S_BRD: begin
                c_re = 1'b1;
            end
            S_BRW: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(r_x);
                mul_b     = MUL_B_W'(p_rdata);
            end
            S_BMW: begin
                if (mul_done) begin
                    t_we    = 1'b1;
                    t_waddr = r_i - AW'(1);
                    t_wdata = to_q16(w_xn);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lam    <= LAMBDA_RST;
            r_ncfg   <= NODES_RST;
            r_init   <= INIT_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LAMBDA: r_lam  <= i_cfg_data;
                    REG_NODES:  r_ncfg <= i_cfg_data[NCFG_W-1:0];
                    REG_INIT:   r_init <= i_cfg_data[TMP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_cmd)
                            CMD_FILL: r_state <= S_FILL;
                            CMD_STEP: r_state <= S_F0;
                            CMD_READ: r_state <= w_in_range ? S_RDW : S_DONE;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_FILL: if (r_i == AW'(MAX_NODES - 1)) r_state <= S_DONE;
                S_RDW:  r_state <= S_DONE;
                S_F0:   r_state <= S_FRD;
                S_FRD:  r_state <= S_FLP;
                S_FLP:  if (mul_done) r_state <= w_last ? S_FMD : S_FDP;
                S_FDP:  if (div_done) r_state <= S_FMD;
                S_FMD:  if (mul_done) r_state <= S_FDD;
                S_FDD:  if (div_done) r_state <= w_last ? S_BST : S_FRD;
                S_BST:  r_state <= S_BRD;
                S_BRD:  r_state <= S_BRW;
                S_BRW:  r_state <= S_BMW;
                S_BMW:  if (mul_done) r_state <= (r_i == AW'(1)) ? S_DONE : S_BRD;
                S_DONE: if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_res <= '0;
                r_err <= w_cmd == CMD_READ && !w_in_range;
                r_i   <= '0;
                r_n   <= w_n;
                r_p   <= '0;
                r_d   <= {w_bnd, 8'b0};
            end
            S_FILL: r_i <= r_i + AW'(1);
            S_RDW:  r_res <= t_rdata;
            S_F0:   r_i <= AW'(1);
            S_FLP: begin
                r_den <= w_den[DEN_W-1:0];
                r_pn  <= '0;
            end
            S_FDP:  if (div_done) r_pn <= div_quo[P_W-1:0];
            S_FDD: begin
                if (div_done) begin
                    r_p <= r_pn;
                    r_d <= w_dn;
                    if (!w_last) r_i <= r_i + AW'(1);
                end
            end
            S_BST: begin
                r_x   <= r_d;
                r_res <= to_q16(r_d);
            end
            S_BMW: begin
                if (mul_done) begin
                    r_x <= w_xn;
                    r_i <= r_i - AW'(1);
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_odata <= r_res;
            r_oerr  <= r_err;
        end
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_m_tdata    = r_odata;
    assign o_m_tuser[0] = r_oerr;

    ihst_ram #(.WIDTH(TMP_W), .DEPTH(MAX_NODES)) u_temp (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_re(t_re), .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    ihst_ram #(.WIDTH(P_W), .DEPTH(MAX_NODES)) u_coef (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(p_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(p_rdata)
    );

    ihst_ram #(.WIDTH(D_W), .DEPTH(MAX_NODES)) u_rhs (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(d_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(d_rdata)
    );

    ihst_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start), .i_a(mul_a),
        .i_b(mul_b), .o_done(mul_done), .o_prod(mul_prod)
    );

    ihst_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quo(div_quo)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("sequencer did not leave idle after a command transfer");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tdata == '0)
        else $error("index error result carries a nonzero value");

    a_back_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BMW || r_state == S_BRD) |-> r_i != '0)
        else $error("back substitution ran past node zero");

    a_unit_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_start && div_start))
        else $error("multiplier and divider started together");

endmodule
